@@ hw/rtl/olist_pkg.sv @@
`timescale 1ns / 1ps

package olist_pkg;

  localparam int DEFAULT_CAPACITY = 32;
  localparam int VALUE_W          = 32;

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_INSERT  = 2'd1,
    MODE_DELETE  = 2'd2,
    MODE_DISPLAY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                      mode;
    logic signed [VALUE_W-1:0]  search_key;
    logic signed [VALUE_W-1:0]  data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  out_value;
    status_t                    status;
    logic                       last;
  } out_item_t;

endpackage

@@ hw/rtl/olist_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read; read data holds while re is low.
module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/olist_alloc.sv @@
`timescale 1ns / 1ps

// Free-slot map; offers the lowest free slot.
module olist_alloc #(
  parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY,
  localparam int AW      = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take_en,
  input  logic          give_en,
  input  logic [AW-1:0] give_idx,
  output logic [AW-1:0] free_idx
);

  logic [CAPACITY-1:0] free_r;

  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
    end else begin
      if (take_en) begin
        free_r[free_idx] <= 1'b0;
      end
      if (give_en) begin
        free_r[give_idx] <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/ordered_list_engine.sv @@
`timescale 1ns / 1ps

// Bounded doubly linked list of signed 32-bit values held in three entry RAMs
// (value, next link, previous link), with head/tail pointers, an entry count
// and a free-slot map; new entries take the lowest free slot. One transaction
// is handled at a time: in_stall is high from acceptance until the sequencer
// is back in idle. Cost is set by the single registered read port shared by
// the list walk, one linked entry per cycle unless out_stall holds back a
// display result. Append steps through accept, write entry, link and respond.
// Insert-left walks to the matching entry, then writes the new entry, links it
// and responds; delete walks to the match, then unlinks it and responds.
// When nothing matches, insert-left and delete answer after walking the whole
// list. A full list answers append and insert without a walk; an empty list
// answers insert, delete and display without one. Display returns one result
// transaction per element, head first, one per cycle when out_stall is low,
// with last set on the tail element. A result held back by out_stall stalls
// the sequencer. A finished result waits in the output register while the
// next request is accepted. No clearing pass is needed after reset.
module ordered_list_engine #(
  parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY,
  localparam int AW      = $clog2(CAPACITY),
  localparam int IDX_W   = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  olist_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output olist_pkg::out_item_t out_data
);

  localparam logic [IDX_W-1:0] NONE = IDX_W'(CAPACITY);
  localparam int VW = olist_pkg::VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_APP_WR,
    S_APP_LINK,
    S_INS_WR,
    S_INS_LINK,
    S_DEL_WR,
    S_RESP
  } state_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] x);
    return x < NONE;
  endfunction

  state_t               state_r;
  olist_pkg::mode_t     mode_r;
  logic [VW-1:0]        target_r;   // search key (insert) or value (delete)
  logic [VW-1:0]        val_r;
  logic [IDX_W-1:0]     head_r;
  logic [IDX_W-1:0]     tail_r;
  logic [IDX_W-1:0]     count_r;
  logic [AW-1:0]        cur_r;      // entry whose read data is on the RAM outputs
  logic [AW-1:0]        steps_r;
  logic [AW-1:0]        t_r;        // matched entry
  logic [IDX_W-1:0]     p_r;        // its previous link
  logic [IDX_W-1:0]     nx_r;       // its next link
  logic [AW-1:0]        n_r;        // newly taken slot
  olist_pkg::status_t   status_r;
  logic                 out_valid_r;
  olist_pkg::out_item_t out_data_r;

  // RAM ports
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [VW-1:0]        rd_value;
  logic [IDX_W-1:0]     rd_next;
  logic [IDX_W-1:0]     rd_prev;
  logic                 val_we;
  logic [AW-1:0]        val_waddr;
  logic [VW-1:0]        val_wdata;
  logic                 next_we;
  logic [AW-1:0]        next_waddr;
  logic [IDX_W-1:0]     next_wdata;
  logic                 prev_we;
  logic [AW-1:0]        prev_waddr;
  logic [IDX_W-1:0]     prev_wdata;

  // Free map
  logic                 take_en;
  logic                 give_en;
  logic [AW-1:0]        free_idx;

  logic                 out_free;
  logic                 full;
  logic                 is_display;
  logic                 hit;
  logic                 end_walk;

  assign out_free   = !out_valid_r || !out_stall;
  assign full       = count_r >= NONE;
  assign is_display = (mode_r == olist_pkg::MODE_DISPLAY);
  assign hit        = (rd_value == target_r);
  // Walk ends at the tail or after CAPACITY visited entries.
  assign end_walk   = !idx_ok(rd_next) || (steps_r == AW'(CAPACITY - 1));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Read port: head on acceptance, then chase the next link straight off the RAM.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        rd_en   = in_valid && idx_ok(head_r);
        rd_addr = head_r[AW-1:0];
      end
      S_WALK: begin
        rd_addr = rd_next[AW-1:0];
        rd_en   = !end_walk && (is_display ? out_free : !hit);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Write ports and free-map commands.
  always_comb begin
    val_we     = 1'b0;
    val_waddr  = free_idx;
    val_wdata  = val_r;
    next_we    = 1'b0;
    next_waddr = free_idx;
    next_wdata = NONE;
    prev_we    = 1'b0;
    prev_waddr = free_idx;
    prev_wdata = tail_r;
    take_en    = 1'b0;
    give_en    = 1'b0;
    unique case (state_r)
      S_APP_WR: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        take_en = 1'b1;
      end
      S_APP_LINK: begin
        next_we    = idx_ok(tail_r);
        next_waddr = tail_r[AW-1:0];
        next_wdata = IDX_W'(n_r);
      end
      S_INS_WR: begin
        val_we     = 1'b1;
        next_we    = 1'b1;
        next_wdata = IDX_W'(t_r);
        prev_we    = 1'b1;
        prev_wdata = p_r;
        take_en    = 1'b1;
      end
      S_INS_LINK: begin
        prev_we    = 1'b1;
        prev_waddr = t_r;
        prev_wdata = IDX_W'(n_r);
        next_we    = idx_ok(p_r);
        next_waddr = p_r[AW-1:0];
        next_wdata = IDX_W'(n_r);
      end
      S_DEL_WR: begin
        next_we    = idx_ok(p_r);
        next_waddr = p_r[AW-1:0];
        next_wdata = nx_r;
        prev_we    = idx_ok(nx_r);
        prev_waddr = nx_r[AW-1:0];
        prev_wdata = p_r;
        give_en    = 1'b1;
      end
      default: begin
        val_we = 1'b0;
      end
    endcase
  end

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= NONE;
      tail_r      <= NONE;
      count_r     <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r   <= in_data.mode;
            val_r    <= in_data.data_value;
            target_r <= (in_data.mode == olist_pkg::MODE_INSERT) ?
                        in_data.search_key : in_data.data_value;
            cur_r    <= head_r[AW-1:0];
            steps_r  <= '0;
            unique case (in_data.mode)
              olist_pkg::MODE_APPEND: begin
                if (full) begin
                  status_r <= olist_pkg::ST_FULL;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_APP_WR;
                end
              end
              olist_pkg::MODE_INSERT: begin
                if (full) begin
                  status_r <= olist_pkg::ST_FULL;
                  state_r  <= S_RESP;
                end else if (!idx_ok(head_r)) begin
                  status_r <= olist_pkg::ST_NOT_FOUND;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_WALK;
                end
              end
              olist_pkg::MODE_DELETE: begin
                if (!idx_ok(head_r)) begin
                  status_r <= olist_pkg::ST_NOT_FOUND;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_WALK;
                end
              end
              olist_pkg::MODE_DISPLAY: begin
                if (!idx_ok(head_r)) begin
                  status_r <= olist_pkg::ST_EMPTY;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_WALK;
                end
              end
            endcase
          end
        end

        S_WALK: begin
          if (is_display) begin
            if (out_free) begin
              out_valid_r          <= 1'b1;
              out_data_r.out_value <= rd_value;
              out_data_r.status    <= olist_pkg::ST_OK;
              out_data_r.last      <= end_walk;
              if (end_walk) begin
                state_r <= S_IDLE;
              end else begin
                cur_r   <= rd_next[AW-1:0];
                steps_r <= steps_r + 1'b1;
              end
            end
          end else if (hit) begin
            t_r  <= cur_r;
            p_r  <= rd_prev;
            nx_r <= rd_next;
            state_r <= (mode_r == olist_pkg::MODE_INSERT) ? S_INS_WR : S_DEL_WR;
          end else if (end_walk) begin
            status_r <= olist_pkg::ST_NOT_FOUND;
            state_r  <= S_RESP;
          end else begin
            cur_r   <= rd_next[AW-1:0];
            steps_r <= steps_r + 1'b1;
          end
        end

        S_APP_WR: begin
          n_r     <= free_idx;
          state_r <= S_APP_LINK;
        end

        S_APP_LINK: begin
          if (!idx_ok(tail_r)) begin
            head_r <= IDX_W'(n_r);
          end
          tail_r   <= IDX_W'(n_r);
          count_r  <= count_r + 1'b1;
          status_r <= olist_pkg::ST_OK;
          state_r  <= S_RESP;
        end

        S_INS_WR: begin
          n_r     <= free_idx;
          state_r <= S_INS_LINK;
        end

        S_INS_LINK: begin
          if (!idx_ok(p_r)) begin
            head_r <= IDX_W'(n_r);
          end
          count_r  <= count_r + 1'b1;
          status_r <= olist_pkg::ST_OK;
          state_r  <= S_RESP;
        end

        S_DEL_WR: begin
          if (!idx_ok(p_r)) begin
            head_r <= nx_r;
          end
          if (!idx_ok(nx_r)) begin
            tail_r <= p_r;
          end
          if (count_r != '0) begin
            count_r <= count_r - 1'b1;
          end
          status_r <= olist_pkg::ST_OK;
          state_r  <= S_RESP;
        end

        S_RESP: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_data_r.out_value <= '0;
            out_data_r.status    <= status_r;
            out_data_r.last      <= 1'b1;
            state_r              <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  olist_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_value)
  );

  olist_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_next)
  );

  olist_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_prev)
  );

  olist_alloc #(.CAPACITY(CAPACITY)) u_alloc (
    .clk      (clk),
    .rst_n    (rst_n),
    .take_en  (take_en),
    .give_en  (give_en),
    .give_idx (t_r),
    .free_idx (free_idx)
  );

endmodule
